[design/uth_pkg.sv]
// Shared types and constants for the URL token hasher.
`timescale 1ns / 1ps
package uth_pkg;

  localparam int unsigned LengthBitsDefault = 32;
  localparam int unsigned QueueDepth        = 4;

  localparam logic [63:0] SeedA = 64'h16f11fe89b0d677c;
  localparam logic [63:0] SeedB = 64'hb480a793d8e6c86c;
  localparam logic [63:0] SeedC = 64'h6fe2e5aaf078ebc9;
  localparam logic [63:0] SeedD = 64'h14f994a4c5259381;
  localparam logic [63:0] MixK  = 64'h6eed0e9da4d94a4f;
  localparam logic [7:0]  StarByte = 8'h2A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_url;
  } uth_in_t;

  typedef struct packed {
    logic [31:0] token_hash;
    logic        last;
  } uth_out_t;

  typedef enum logic [1:0] {
    CMD_CHUNK = 2'd0,
    CMD_FINAL = 2'd1,
    CMD_END   = 2'd2
  } uth_kind_e;

  // One unit of work for the hash back end.
  typedef struct packed {
    uth_kind_e   kind;
    logic        first;
    logic [63:0] data;
  } uth_cmd_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_MIX  = 2'd1,
    B_OUT  = 2'd2
  } uth_bstate_e;

  function automatic logic is_word_byte(logic [7:0] v);
    return (v >= 8'h30 && v <= 8'h39) || (v >= 8'h41 && v <= 8'h5A) ||
           (v >= 8'h61 && v <= 8'h7A);
  endfunction

endpackage

[design/uth_fifo.sv]
// Small command queue between the tokenizer and the hash back end.
`timescale 1ns / 1ps
module uth_fifo
  import uth_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  uth_cmd_t push_cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output uth_cmd_t pop_cmd_o,
  output logic     empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  uth_cmd_t        mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [AW:0]     cnt_q;

  assign full_o    = (cnt_q == (AW+1)'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = mem_q[rd_q];

  // Store commands
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_cmd_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
`endif

endmodule

[design/uth_front.sv]
// Tokenizer: classifies URL bytes, builds chunks and issues hash commands.
`timescale 1ns / 1ps
module uth_front
  import uth_pkg::*;
#(
  parameter int unsigned LengthBits = LengthBitsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  uth_in_t  in_req_i,
  output logic     push_o,
  output uth_cmd_t push_cmd_o,
  input  logic     full_i
);

  uth_cmd_t              cmd_q [3];
  uth_cmd_t              cmd_d [3];
  logic [1:0]            head_q, head_d, cnt_q, cnt_d;
  logic                  inside_q, inside_d, prev_q, prev_d, sbt_q, sbt_d;
  logic                  first_q, first_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic [55:0]           pb_q, pb_d;
  logic [2:0]            pc_q, pc_d;
  logic                  accept;

  assign in_stall_o = (cnt_q != '0);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = (cnt_q != '0) && !full_i;
  assign push_cmd_o = cmd_q[head_q];

  // Classify the byte and compute the new token state and command list
  always_comb begin
    logic [7:0] v;
    logic       ok;
    inside_d = inside_q;
    prev_d   = prev_q;
    sbt_d    = sbt_q;
    first_d  = first_q;
    len_d    = len_q;
    pb_d     = pb_q;
    pc_d     = pc_q;
    cmd_d    = cmd_q;
    head_d   = head_q;
    cnt_d    = cnt_q;
    v        = in_req_i.data_byte;
    ok       = 1'b0;

    if (push_o) begin
      head_d = head_q + 1'b1;
      cnt_d  = cnt_q - 1'b1;
    end

    if (accept) begin
      head_d = '0;
      cnt_d  = '0;
      if (in_req_i.byte_valid) begin
        if (is_word_byte(v)) begin
          if (!inside_d) begin
            inside_d = 1'b1;
            len_d    = '0;
            pb_d     = '0;
            pc_d     = '0;
            sbt_d    = prev_q;
            first_d  = 1'b1;
          end
          len_d = len_d + 1'b1;
          if (pc_d == 3'd7) begin
            cmd_d[cnt_d] = '{kind: CMD_CHUNK, first: first_d, data: {v, pb_d}};
            cnt_d   = cnt_d + 1'b1;
            first_d = 1'b0;
            pb_d    = '0;
            pc_d    = '0;
          end else begin
            pb_d = pb_d | (56'(v) << {pc_d, 3'b000});
            pc_d = pc_d + 1'b1;
          end
        end else if (inside_d) begin
          ok = (len_d >= LengthBits'(2)) && !sbt_d && (v != StarByte);
          if (ok) begin
            cmd_d[cnt_d] = '{kind: CMD_FINAL, first: first_d,
                             data: 64'(len_d) | {pb_d, 8'h00}};
            cnt_d = cnt_d + 1'b1;
          end
          inside_d = 1'b0;
        end
        prev_d = (v == StarByte);
      end
      if (in_req_i.end_of_url) begin
        if (inside_d) begin
          ok = (len_d >= LengthBits'(2)) && !sbt_d;
          if (ok) begin
            cmd_d[cnt_d] = '{kind: CMD_FINAL, first: first_d,
                             data: 64'(len_d) | {pb_d, 8'h00}};
            cnt_d = cnt_d + 1'b1;
          end
        end
        cmd_d[cnt_d] = '{kind: CMD_END, first: 1'b0, data: '0};
        cnt_d    = cnt_d + 1'b1;
        inside_d = 1'b0;
        prev_d   = 1'b0;
        sbt_d    = 1'b0;
        first_d  = 1'b0;
        len_d    = '0;
        pb_d     = '0;
        pc_d     = '0;
      end
    end
  end

  // Hold pending commands
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  // Token state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      cnt_q    <= '0;
      inside_q <= 1'b0;
      prev_q   <= 1'b0;
      sbt_q    <= 1'b0;
      first_q  <= 1'b0;
      len_q    <= '0;
      pb_q     <= '0;
      pc_q     <= '0;
    end else begin
      head_q   <= head_d;
      cnt_q    <= cnt_d;
      inside_q <= inside_d;
      prev_q   <= prev_d;
      sbt_q    <= sbt_d;
      first_q  <= first_d;
      len_q    <= len_d;
      pb_q     <= pb_d;
      pc_q     <= pc_d;
    end
  end

endmodule

[design/uth_mix.sv]
// Iterative diffusion unit: multiply, xor-shift, multiply on one 32x32 multiplier.
`timescale 1ns / 1ps
module uth_mix
  import uth_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] y_o
);

  logic [2:0]  ph_q;
  logic        busy_q, done_q;
  logic [63:0] m_q, acc_q;
  logic [1:0]  idx;
  logic [31:0] op_a, op_b;
  logic [63:0] prod;

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign y_o    = acc_q;

  // Select the partial product for this phase
  always_comb begin
    idx  = (ph_q >= 3'd4) ? 2'(ph_q - 3'd4) : ph_q[1:0];
    op_a = (idx == 2'd2) ? m_q[63:32] : m_q[31:0];
    op_b = (idx == 2'd1) ? MixK[63:32] : MixK[31:0];
    prod = 64'(op_a) * 64'(op_b);
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q <= x_i;
    end else if (busy_q) begin
      if (ph_q == 3'd3) begin
        m_q <= acc_q ^ ((acc_q >> 32) >> acc_q[63:60]);
      end else if (idx == 2'd0) begin
        acc_q <= prod;
      end else begin
        acc_q <= acc_q + {prod[31:0], 32'h0};
      end
    end
  end

  // Phase control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        ph_q   <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        ph_q <= ph_q + 1'b1;
        if (ph_q == 3'd6) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("mix started while busy");
`endif

endmodule

[design/uth_back.sv]
// Hash back end: keeps the four lanes, runs chunk and finalization diffusion.
`timescale 1ns / 1ps
module uth_back
  import uth_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  uth_cmd_t cmd_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output uth_out_t out_req_o
);

  uth_bstate_e state_q, state_d;
  uth_kind_e   kind_q;
  logic [63:0] la_q, lb_q, lc_q, ld_q, acc_q, acc_d;
  logic [2:0]  step_q;
  logic        mix_start, mix_busy, mix_done;
  logic [63:0] mix_x, mix_y;
  uth_out_t    res_q, out_q;
  logic        out_valid_q, slot_free;

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;
  assign slot_free   = !out_valid_q || !out_stall_i;

  uth_mix u_mix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mix_start),
    .x_i    (mix_x),
    .busy_o (mix_busy),
    .done_o (mix_done),
    .y_o    (mix_y)
  );

  // Next state and mix operand selection
  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    mix_start = 1'b0;
    mix_x     = '0;
    acc_d     = (step_q == 3'd0) ? mix_y : acc_q ^ mix_y;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (cmd_i.kind == CMD_END) begin
            state_d = B_OUT;
          end else begin
            mix_start = 1'b1;
            mix_x     = (cmd_i.first ? SeedA : la_q) ^ cmd_i.data;
            state_d   = B_MIX;
          end
        end
      end
      B_MIX: begin
        if (mix_done) begin
          if (kind_q != CMD_FINAL) begin
            state_d = B_IDLE;
          end else if (step_q == 3'd4) begin
            state_d = B_OUT;
          end else begin
            mix_start = 1'b1;
            case (step_q)
              3'd0:    mix_x = lb_q;
              3'd1:    mix_x = lc_q;
              3'd2:    mix_x = ld_q;
              default: mix_x = acc_d;
            endcase
          end
        end
      end
      B_OUT: begin
        if (slot_free) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Lanes, accumulator and result
  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && !empty_i) begin
      kind_q <= cmd_i.kind;
      step_q <= '0;
      res_q  <= '{token_hash: 32'h0, last: 1'b1};
      if (cmd_i.first) begin
        la_q <= SeedA;
        lb_q <= SeedB;
        lc_q <= SeedC;
        ld_q <= SeedD;
      end
    end else if (state_q == B_MIX && mix_done) begin
      if (kind_q == CMD_CHUNK) begin
        la_q <= lb_q;
        lb_q <= lc_q;
        lc_q <= ld_q;
        ld_q <= mix_y;
      end else begin
        acc_q  <= acc_d;
        step_q <= step_q + 1'b1;
        res_q  <= '{token_hash: mix_y[31:0], last: 1'b0};
      end
    end
    if (state_q == B_OUT && slot_free) out_q <= res_q;
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_OUT && slot_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)             out_valid_q <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last) |-> (out_q.token_hash == 32'h0))
    else $error("closing entry carries a nonzero hash");
  a_mix_when_mixing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_busy |-> (state_q == B_MIX)) else $error("mix running outside mix state");
`endif

endmodule

[design/url_token_hasher.sv]
// Top level of the URL token hasher: tokenizer, command queue, hash back end.
//
//   channel | direction | handshake                | payload
//   in      | request in  | in_valid_i / in_stall_o  | in_req_i  (uth_in_t)
//   out     | request out | out_valid_o / out_stall_i| out_req_o (uth_out_t)
//
// The tokenizer stalls the input while it holds commands not yet pushed to the queue;
// one request issues at most three commands (chunk, token hash, closing entry).
// Each diffusion runs on the shared 32x32 multiplier: a full chunk takes one diffusion,
// a token finalization five.
// A 4-deep command queue lets the tokenizer run ahead; a full queue holds its commands back.
// Reset is asynchronous; no clearing pass is needed.
`timescale 1ns / 1ps
module url_token_hasher
  import uth_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  uth_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output uth_out_t out_req_o
);

  logic     push, full, pop, empty;
  uth_cmd_t push_cmd, pop_cmd;

  uth_front #(.LengthBits(LENGTH_BITS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_req_i  (in_req_i),
    .push_o    (push),
    .push_cmd_o(push_cmd),
    .full_i    (full)
  );

  uth_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (full),
    .pop_i     (pop),
    .pop_cmd_o (pop_cmd),
    .empty_o   (empty)
  );

  uth_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .cmd_i      (pop_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

endmodule

[verif/url_token_hasher_tb.sv]
// Self-checking testbench for the URL token hasher: tokenizing, hashing and closing entries.
`timescale 1ns / 1ps
module url_token_hasher_tb;
  import uth_pkg::*;

  localparam int unsigned LenBits = LengthBitsDefault;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  uth_in_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  uth_out_t out_req_o;

  url_token_hasher #(.LENGTH_BITS(LenBits)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  // Predictor state: lanes, pending chunk and token bookkeeping.
  logic [63:0] lane_a, lane_b, lane_c, lane_d;
  logic [55:0] chunk_bytes;
  int unsigned chunk_fill;
  logic [63:0] tok_len;
  logic        in_tok, last_star, star_lead;

  uth_out_t    hash_q[$];
  int unsigned errors;
  int unsigned sent_reqs;
  int unsigned got_hashes;
  bit          idle_en;
  int unsigned hold_cycles;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [63:0] diffuse(logic [63:0] x);
    logic [63:0] y;
    y = x * MixK;
    y = y ^ ((y >> 32) >> y[63:60]);
    return y * MixK;
  endfunction

  function automatic logic word_char(logic [7:0] v);
    return (v >= "0" && v <= "9") || (v >= "A" && v <= "Z") || (v >= "a" && v <= "z");
  endfunction

  function automatic logic [63:0] len_wrap(logic [63:0] x);
    if (LenBits >= 64) return x;
    return x & ((64'd1 << LenBits) - 64'd1);
  endfunction

  // Append one expected result.
  task automatic expect_result(uth_out_t r);
    hash_q = {hash_q, r};
  endtask

  task automatic clear_hash_state();
    lane_a = SeedA;
    lane_b = SeedB;
    lane_c = SeedC;
    lane_d = SeedD;
    chunk_bytes = '0;
    chunk_fill = 0;
    tok_len = '0;
  endtask

  // Close the open token and queue its hash if it qualifies.
  task automatic close_token(logic star_after);
    logic [63:0] tail;
    logic [63:0] h;
    uth_out_t r;
    if (in_tok && tok_len >= 2 && !star_lead && !star_after) begin
      tail = tok_len | ({8'h00, chunk_bytes} << 8);
      h = diffuse(diffuse(lane_a ^ tail) ^ diffuse(lane_b) ^ diffuse(lane_c)
                  ^ diffuse(lane_d));
      r.token_hash = h[31:0];
      r.last = 1'b0;
      expect_result(r);
    end
    in_tok = 1'b0;
  endtask

  task automatic predict_url_step(uth_in_t req);
    logic [63:0] na;
    uth_out_t r;
    if (req.byte_valid) begin
      if (word_char(req.data_byte)) begin
        if (!in_tok) begin
          clear_hash_state();
          star_lead = last_star;
          in_tok = 1'b1;
        end
        tok_len = len_wrap(tok_len + 1);
        if (chunk_fill >= 7) begin
          na = diffuse(lane_a ^ {req.data_byte, chunk_bytes});
          lane_a = lane_b;
          lane_b = lane_c;
          lane_c = lane_d;
          lane_d = na;
          chunk_bytes = '0;
          chunk_fill = 0;
        end else begin
          chunk_bytes = chunk_bytes | (56'(req.data_byte) << (8 * chunk_fill));
          chunk_fill++;
        end
      end else if (in_tok) begin
        close_token(req.data_byte == StarByte);
      end
      last_star = (req.data_byte == StarByte);
    end
    if (req.end_of_url) begin
      if (in_tok) close_token(1'b0);
      r.token_hash = '0;
      r.last = 1'b1;
      expect_result(r);
      clear_hash_state();
      in_tok = 1'b0;
      last_star = 1'b0;
      star_lead = 1'b0;
    end
  endtask

  // Offer one request, hold it until accepted, then update the prediction.
  task automatic send_req(logic [7:0] b, logic bv, logic eou);
    uth_in_t req;
    int unsigned gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.data_byte = b;
    req.byte_valid = bv;
    req.end_of_url = eou;
    in_req_i <= req;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_url_step(req);
    sent_reqs++;
  endtask

  task automatic send_text(string s, logic eou);
    for (int i = 0; i < s.len(); i++) send_req(s[i], 1'b1, eou && (i == s.len() - 1));
  endtask

  // Stop offering and wait until every expected result has come.
  task automatic drain_hashes();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (hash_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom_range("a", "z"));
      3, 4:    return 8'($urandom_range("A", "Z"));
      5:       return 8'($urandom_range("0", "9"));
      6:       return StarByte;
      7:       return "/";
      8:       return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: random stall bursts, optionally a long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cycles != 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= $urandom_range(0, 8);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    uth_out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hash_q.size() == 0) begin
        $display("%0t: unexpected result hash=%h last=%b", $time,
                 out_req_o.token_hash, out_req_o.last);
        errors++;
      end else begin
        exp_r = hash_q.pop_front();
        if (!exp_r.last) got_hashes++;
        if (exp_r.token_hash !== out_req_o.token_hash)
          begin
          $display("%0t: token_hash expected %h actual %h", $time,
                   exp_r.token_hash, out_req_o.token_hash);
          errors++;
        end
        if (exp_r.last !== out_req_o.last) begin
          $display("%0t: last expected %b actual %b", $time, exp_r.last, out_req_o.last);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_req(8'h00, 1'b0, 1'b1);
    send_req(8'h00, 1'b0, 1'b0);
    send_text("ab", 1'b1);
    send_text("a/Zz9", 1'b1);
    send_text("abcdefgh/abcdefghijklmno*x", 1'b0);
    send_text("*ab/cd*/ef", 1'b0);
    send_req(8'hFF, 1'b1, 1'b0);
    send_text("09AZaz", 1'b0);
    send_req(8'h80, 1'b1, 1'b0);
    send_req(8'h7F, 1'b1, 1'b1);
    drain_hashes();
  endtask

  task automatic test_long_tokens();
    for (int n = 0; n < 4; n++) begin
      for (int i = 0; i < 8 + $urandom_range(0, 24); i++)
        send_req(8'($urandom_range("a", "z")), 1'b1, 1'b0);
      send_req("?", 1'b1, 1'b0);
    end
    send_req(8'h00, 1'b0, 1'b1);
  endtask

  // Let results pile up while the input keeps offering requests.
  task automatic test_backpressure();
    drain_hashes();
    @(negedge clk_i);
    hold_cycles = 300;
    @(posedge clk_i);
    send_text("host/path/index/query/more/items/deep/words/end", 1'b1);
    drain_hashes();
  endtask

  task automatic test_random_urls(int unsigned n_reqs);
    int unsigned stop_at;
    stop_at = sent_reqs + n_reqs;
    while (sent_reqs < stop_at) begin
      for (int i = 0; i < $urandom_range(1, 30); i++) begin
        if ($urandom_range(0, 30) == 0) send_req(8'($urandom), 1'b0, 1'b0);
        else send_req(pick_byte(), 1'b1, 1'b0);
      end
      send_req(pick_byte(), 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    hold_cycles = 0;
    errors = 0;
    sent_reqs = 0;
    got_hashes = 0;
    idle_en = 1'b1;
    clear_hash_state();
    in_tok = 1'b0;
    last_star = 1'b0;
    star_lead = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_long_tokens();
    test_backpressure();
    test_random_urls(950);
    drain_hashes();
    idle_en = 1'b0;
    test_random_urls(300);
    drain_hashes();
    repeat (100) @(posedge clk_i);
    $display("Fed %0d URL bytes/markers; checked %0d token hashes plus end entries.",
             sent_reqs, got_hashes);
    if (errors == 0 && hash_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
